// ===== src/wav_stream_writer_macros.svh =====
// ----------------------------------------------------------------------------
// wav_stream_writer_macros
// Assertion shorthands used by the stream writer job queue (wsw_fifo).
// ----------------------------------------------------------------------------
`ifndef WAV_STREAM_WRITER_MACROS_SVH
`define WAV_STREAM_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsw assertion failed");

`endif

// ===== src/wsw_pkg.sv =====
// ----------------------------------------------------------------------------
// wsw_pkg
// Types, constants and config helpers for the WAVE stream writer.
// ----------------------------------------------------------------------------
package wsw_pkg;

    localparam logic       OP_BEGIN  = 1'b0;
    localparam logic       OP_SAMPLE = 1'b1;

    localparam logic [1:0] FMT_INT16 = 2'd0;
    localparam logic [1:0] FMT_INT24 = 2'd1;
    localparam logic [1:0] FMT_INT32 = 2'd2;
    localparam logic [1:0] FMT_FLT32 = 2'd3;

    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_FORMAT   = 2'd1;
    localparam logic [1:0] REG_RATE     = 2'd2;
    localparam logic [1:0] REG_FRAMES   = 2'd3;

    localparam logic [5:0] HDR_LEN_PCM = 6'd44;
    localparam logic [5:0] HDR_LEN_FLT = 6'd58;
    localparam int         HDR_MAX     = 58;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952; // "RIFF" little-endian
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    typedef struct packed {
        logic        op;
        logic [31:0] sample_bits;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       file_end;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  channel_count;
        logic [1:0]  sample_format;
        logic [31:0] sample_rate;
        logic [31:0] frame_count;
    } t_cfg;

    // One unit of output work: a header or a sample's bytes (plus pad).
    typedef struct packed {
        logic        hdr;
        logic [31:0] word;
        logic [5:0]  len;
        logic        last;
    } t_job;

    function automatic logic [1:0] eff_ch(input logic [1:0] cc);
        logic [1:0] c;
        c = cc;
        if (cc == 2'd0) c = 2'd1;
        if (cc == 2'd3) c = 2'd2;
        return c;
    endfunction

    function automatic logic [2:0] bytes_per_sample(input logic [1:0] fmt);
        logic [2:0] b;
        unique case (fmt)
            FMT_INT16: b = 3'd2;
            FMT_INT24: b = 3'd3;
            default:   b = 3'd4;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] frame_bytes(input t_cfg c);
        return 4'(bytes_per_sample(c.sample_format)) * 4'(eff_ch(c.channel_count));
    endfunction

    function automatic logic [31:0] data_bytes(input t_cfg c);
        return 32'(c.frame_count * 32'(frame_bytes(c)));
    endfunction

    function automatic logic [32:0] total_samples(input t_cfg c);
        return (eff_ch(c.channel_count) == 2'd2) ? {c.frame_count, 1'b0}
                                                 : {1'b0, c.frame_count};
    endfunction

endpackage

// ===== src/wav_stream_writer.sv =====
// ----------------------------------------------------------------------------
// wav_stream_writer
// RIFF/WAVE byte stream generator with PCM conversion (float32 passes through) and an APB config port.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  in        sink       i_in_valid / o_in_ready      t_in_item  (op, sample_bits)
//  out       source     o_out_valid / i_out_ready    t_out_item (out_byte, file_end)
//  config    APB slave  psel / penable / pready      paddr[3:2] register, pwdata
//
//  One byte leaves per cycle while jobs are queued and the output is not stalled; a sample is 2 to 4 bytes
//  (its bytes, plus a pad byte after the last int24 sample of odd-length data),
//  a header 44 or 58.
//  Conversion happens at input transfer; a two-entry job queue lets inputs
//  run ahead of the sequencer by two jobs.
//  Synchronous active-low reset closes the file and restores register defaults.
//  A stalled output holds its byte; the input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module wav_stream_writer
    import wsw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg r_cfg;
    logic wr_en;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    t_job q_in;
    t_job q_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count <= 2'd1;
            r_cfg.sample_format <= FMT_INT16;
            r_cfg.sample_rate   <= 32'd44100;
            r_cfg.frame_count   <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_CHANNELS: r_cfg.channel_count <= pwdata[1:0];
                REG_FORMAT:   r_cfg.sample_format <= pwdata[1:0];
                REG_RATE:     r_cfg.sample_rate   <= pwdata;
                default:      r_cfg.frame_count   <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CHANNELS: prdata = {30'b0, r_cfg.channel_count};
            REG_FORMAT:   prdata = {30'b0, r_cfg.sample_format};
            REG_RATE:     prdata = r_cfg.sample_rate;
            default:      prdata = r_cfg.frame_count;
        endcase
    end

    wsw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_job    (q_in)
    );

    wsw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    wsw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (q_out),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== src/wsw_front.sv =====
// ----------------------------------------------------------------------------
// wsw_front
// Accepts input items, tracks the open file and converts samples to codes.
// ----------------------------------------------------------------------------
module wsw_front
    import wsw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_job     o_q_job
);

    logic        r_open;
    logic [32:0] r_done;
    logic        n_open;
    logic [32:0] n_done;

    logic        accept;
    logic [31:0] dbytes;
    logic        pad;
    logic [32:0] done_inc;
    logic        closing;
    logic [2:0]  bps;

    // sample conversion
    logic        sgn;
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [4:0]  nm1;
    logic signed [9:0] ex;
    logic [31:0] shifted;
    logic [32:0] rnd;
    logic [32:0] lim;
    logic [32:0] mag;
    logic [32:0] code;
    logic [31:0] word;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign dbytes     = data_bytes(i_cfg);
    assign pad        = dbytes[0];
    assign done_inc   = r_done + 33'd1;
    assign closing    = done_inc >= total_samples(i_cfg);
    assign bps        = bytes_per_sample(i_cfg.sample_format);

    always_comb begin
        sgn  = i_in_item.sample_bits[31];
        expo = i_in_item.sample_bits[30:23];
        mant = {1'b1, i_in_item.sample_bits[22:0]};
        case (i_cfg.sample_format)
            FMT_INT16: nm1 = 5'd15;
            FMT_INT24: nm1 = 5'd23;
            default:   nm1 = 5'd31;
        endcase
        ex      = $signed({2'b00, expo}) - 10'sd127 + $signed({5'b0, nm1});
        // value*2 before rounding; shift range stays 0..31 inside the live window
        shifted = {mant, 8'b0} >> 5'(10'sd30 - ex);
        rnd     = ({1'b0, shifted} + 33'd1) >> 1;
        lim     = sgn ? (33'd1 << nm1) : ((33'd1 << nm1) - 33'd1);
        if ((expo == 8'hff && i_in_item.sample_bits[22:0] != 23'd0) || expo == 8'd0
            || ex < -10'sd1) begin
            mag = '0;
        end else if (ex >= $signed({5'b0, nm1})) begin
            mag = lim;
        end else begin
            mag = (rnd > lim) ? lim : rnd;
        end
        code = sgn ? (33'd0 - mag) : mag;
        case (i_cfg.sample_format)
            FMT_INT16: word = {16'b0, code[15:0]};
            FMT_INT24: word = {8'b0, code[23:0]};
            FMT_INT32: word = code[31:0];
            default:   word = i_in_item.sample_bits;
        endcase
    end

    always_comb begin
        n_open   = r_open;
        n_done   = r_done;
        o_q_push = 1'b0;
        o_q_job  = '0;
        if (accept) begin
            if (i_in_item.op == OP_BEGIN) begin
                o_q_push     = 1'b1;
                o_q_job.hdr  = 1'b1;
                o_q_job.len  = (i_cfg.sample_format == FMT_FLT32) ? HDR_LEN_FLT : HDR_LEN_PCM;
                o_q_job.last = (i_cfg.frame_count == 32'd0);
                n_done       = '0;
                n_open       = (i_cfg.frame_count != 32'd0);
            end else if (r_open) begin
                o_q_push     = 1'b1;
                o_q_job.word = word;
                o_q_job.last = closing;
                o_q_job.len  = 6'(bps) + 6'(closing && pad);
                n_done       = done_inc;
                n_open       = !closing;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_done <= '0;
        end else begin
            r_open <= n_open;
            r_done <= n_done;
        end
    end

endmodule

// ===== src/wsw_fifo.sv =====
// ----------------------------------------------------------------------------
// wsw_fifo
// Two-entry job queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
`include "wav_stream_writer_macros.svh"

module wsw_fifo
    import wsw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    `WSW_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `WSW_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)
    `WSW_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= 2'd2)

endmodule

// ===== src/wsw_back.sv =====
// ----------------------------------------------------------------------------
// wsw_back
// Byte sequencer: walks one job at a time and emits one byte per transfer.
// ----------------------------------------------------------------------------
module wsw_back
    import wsw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_job      i_job,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_busy;
    t_job      r_job;
    logic [5:0] r_idx;
    logic      r_ov;
    t_out_item r_out;

    logic        step;
    logic        last_step;
    logic [7:0]  hb [HDR_MAX];
    logic [7:0]  cur;
    logic        flt;
    logic [31:0] dbytes;
    logic [31:0] riff_size;
    logic [31:0] byte_rate;
    logic [15:0] fb;
    logic [15:0] bits16;

    assign step      = r_busy && (!r_ov || i_out_ready);
    assign last_step = step && (r_idx == r_job.len - 6'd1);
    assign o_pop     = !i_empty && (!r_busy || last_step);

    assign flt       = (i_cfg.sample_format == FMT_FLT32);
    assign dbytes    = data_bytes(i_cfg);
    assign riff_size = 32'(flt ? HDR_LEN_FLT - 6'd8 : HDR_LEN_PCM - 6'd8) + dbytes
                       + 32'(dbytes[0]);
    assign byte_rate = 32'(i_cfg.sample_rate * 32'(frame_bytes(i_cfg)));
    assign fb        = 16'(frame_bytes(i_cfg));
    assign bits16    = 16'({bytes_per_sample(i_cfg.sample_format), 3'b000});

    always_comb begin
        for (int i = 0; i < HDR_MAX; i++) hb[i] = 8'h00;
        for (int j = 0; j < 4; j++) begin
            hb[0 + j]  = TAG_RIFF[8*j +: 8];
            hb[4 + j]  = riff_size[8*j +: 8];
            hb[8 + j]  = TAG_WAVE[8*j +: 8];
            hb[12 + j] = TAG_FMT[8*j +: 8];
            hb[24 + j] = i_cfg.sample_rate[8*j +: 8];
            hb[28 + j] = byte_rate[8*j +: 8];
        end
        hb[16] = flt ? 8'd18 : 8'd16;
        hb[20] = flt ? 8'h03 : 8'h01;
        hb[22] = 8'(eff_ch(i_cfg.channel_count));
        hb[32] = fb[7:0];
        hb[33] = fb[15:8];
        hb[34] = bits16[7:0];
        hb[35] = bits16[15:8];
        if (flt) begin
            // cbSize stays zero at 36..37, then the fact chunk
            for (int j = 0; j < 4; j++) begin
                hb[38 + j] = TAG_FACT[8*j +: 8];
                hb[46 + j] = i_cfg.frame_count[8*j +: 8];
                hb[50 + j] = TAG_DATA[8*j +: 8];
                hb[54 + j] = dbytes[8*j +: 8];
            end
            hb[42] = 8'd4;
        end else begin
            for (int j = 0; j < 4; j++) begin
                hb[36 + j] = TAG_DATA[8*j +: 8];
                hb[40 + j] = dbytes[8*j +: 8];
            end
        end
        // upper word bytes are zero, so the pad byte falls out of the same select
        if (r_job.hdr) begin
            cur = hb[r_idx];
        end else begin
            case (r_idx[1:0])
                2'd0:    cur = r_job.word[7:0];
                2'd1:    cur = r_job.word[15:8];
                2'd2:    cur = r_job.word[23:16];
                default: cur = r_job.word[31:24];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.out_byte <= cur;
            r_out.file_end <= r_job.last && (r_idx == r_job.len - 6'd1);
        end
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (step) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (last_step) begin
                r_busy <= 1'b0;
            end else if (step) begin
                r_idx <= r_idx + 6'd1;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

endmodule
